>>> rtl/core/gtsc_pkg.sv
// gtsc_pkg: shared types and constants of the three-sigma outlier classifier
// used by gtsc_ctrl, gtsc_dp and gaussian_three_sigma_classifier_top; no dependencies
package gtsc_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int Z_W             = 4;
    localparam logic [Z_W-1:0] Z_RESET = 4'd3;
    localparam int DG              = 16;
    localparam int K_W             = 4;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef struct packed {
        logic                       kind;
        logic                       new_set;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic in_class;
        logic untrained;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_NSQ = 2'd0,
        OP_SSQ = 2'd1,
        OP_DSQ = 2'd2,
        OP_BND = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIFF = 4'b0010,
        S_MAC  = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    typedef struct packed {
        logic           train;
        logic           load;
        logic           diff;
        logic           mac;
        logic           first;
        logic [K_W-1:0] k;
        t_op            op;
        logic           store;
        t_op            sop;
        logic           out_load;
    } t_cmd;

endpackage

>>> rtl/core/gaussian_three_sigma_classifier_top.sv
// gaussian_three_sigma_classifier_top: one-class three-sigma outlier classifier
// depends on gtsc_pkg, gtsc_ctrl and gtsc_dp
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (z_limit)
//
// a training item does not stall the input; the next item can follow right behind it
// a classify item stalls the input until its result is loaded; its four products of ND 16-bit digits,
// ND = ceil((SAMPLE_BITS + clog2(MAX_SAMPLES+1) + 2) / 16), run one digit per cycle
// through a single shared multiplier
// a finished result sits in the output register; only a second result waits on i_out_stall
// synchronous active-low reset clears the sample count, sum and sum of squares and sets z_limit to 3
module gaussian_three_sigma_classifier_top
    import gtsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  t_in_item       i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output t_out_item      o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [Z_W-1:0] i_cfg_data
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    gtsc_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_in_data.kind),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gtsc_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.kind) |=> o_in_stall)
        else $error("classify item did not start a pass");

    a_train_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_in_data.kind) |=> !o_in_stall)
        else $error("training item blocked the input");

    a_store_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.store |-> $past(cmd.mac))
        else $error("product store without a multiply step");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_out_valid)
        else $error("result loaded but not shown");

endmodule

>>> rtl/core/gtsc_ctrl.sv
// gtsc_ctrl: sequencer for training updates and the four-multiply classify pass
// depends on gtsc_pkg
module gtsc_ctrl
    import gtsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_kind,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int DW = SAMPLE_BITS + CW + 2;
    localparam int ND = (DW + DG - 1) / DG;
    localparam logic [K_W-1:0] K_LAST = K_W'(ND - 1);

    t_state         r_state, n_state;
    t_op            r_op, n_op;
    logic [K_W-1:0] r_k, n_k;
    logic           r_store, n_store;
    t_op            r_sop, n_sop;
    logic           r_out_valid, n_out_valid;
    logic           accept;
    logic           out_free;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_k      = r_k;
        n_store  = 1'b0;
        n_sop    = r_sop;
        o_cmd    = '0;
        o_cmd.k  = r_k;
        o_cmd.op = r_op;
        o_cmd.first = (r_k == '0);
        o_cmd.store = r_store;
        o_cmd.sop   = r_sop;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_kind) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF;
                end else if (accept) begin
                    o_cmd.train = 1'b1;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_op       = OP_NSQ;
                n_k        = '0;
                n_state    = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_k == K_LAST) begin
                    n_k   = '0;
                    n_sop = r_op;
                    if (r_op == OP_BND) begin
                        n_state = S_CMP;
                    end else begin
                        n_store = 1'b1;
                        n_op    = t_op'(r_op + 2'd1);
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_CMP: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NSQ;
            r_k         <= '0;
            r_store     <= 1'b0;
            r_sop       <= OP_NSQ;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_k         <= n_k;
            r_store     <= n_store;
            r_sop       <= n_sop;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/gtsc_dp.sv
// gtsc_dp: accumulators, shared digit-serial multiplier and result register
// depends on gtsc_pkg; driven by gtsc_ctrl commands
module gtsc_dp
    import gtsc_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    input  t_in_item       i_in_data,
    input  logic           i_cfg_we,
    input  logic [Z_W-1:0] i_cfg_data,
    output t_out_item      o_out_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SB + CW;
    localparam int SQ_W  = 2 * SB + CW;
    localparam int NXW   = CW + 1 + SB;
    localparam int DW    = SB + CW + 2;
    localparam int VW    = SQ_W + CW;
    localparam int AW    = VW;
    localparam int ND    = (DW + DG - 1) / DG;
    localparam int BP    = ND * DG;
    localparam int PW    = AW + BP;
    localparam int ZSQ_W = 2 * Z_W;

    logic [Z_W-1:0]           r_z;
    logic [CW-1:0]            r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]          r_sumsq;
    logic signed [NXW-1:0]    r_nx;
    logic [SUM_W-1:0]         r_smag;
    logic [DW-1:0]            r_dmag;
    logic [VW-1:0]            r_var;
    logic [2*DW-1:0]          r_dsq;
    logic [PW-1:0]            r_acc;
    t_out_item                r_out;

    logic signed [SB-1:0]     x;
    logic signed [2*SB-1:0]   xx;
    logic [CW-1:0]            c0;
    logic signed [SUM_W-1:0]  s0;
    logic [SQ_W-1:0]          q0;
    logic signed [DW-1:0]     d;
    logic [ZSQ_W-1:0]         zsq;
    logic [AW-1:0]            a_sel;
    logic [BP-1:0]            b_sel;
    logic [DG-1:0]            dig;
    logic [AW+DG-1:0]         prod;
    logic [PW-1:0]            n_acc;

    assign x   = SB'(i_in_data.sample);
    assign xx  = x * x;
    assign c0  = i_in_data.new_set ? '0 : r_count;
    assign s0  = i_in_data.new_set ? '0 : r_sum;
    assign q0  = i_in_data.new_set ? '0 : r_sumsq;
    assign d   = DW'(r_nx) - DW'(r_sum);
    assign zsq = ZSQ_W'(r_z) * ZSQ_W'(r_z);

    always_comb begin
        unique case (i_cmd.op)
            OP_NSQ: begin
                a_sel = AW'(r_sumsq);
                b_sel = BP'(r_count);
            end
            OP_SSQ: begin
                a_sel = AW'(r_smag);
                b_sel = BP'(r_smag);
            end
            OP_DSQ: begin
                a_sel = AW'(r_dmag);
                b_sel = BP'(r_dmag);
            end
            OP_BND: begin
                a_sel = r_var;
                b_sel = BP'(zsq);
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    assign dig   = b_sel[DG*i_cmd.k +: DG];
    assign prod  = (AW+DG)'(a_sel) * (AW+DG)'(dig);
    assign n_acc = (i_cmd.first ? '0 : r_acc) + (PW'(prod) << (DG * i_cmd.k));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z     <= Z_RESET;
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
        end else begin
            if (i_cfg_we) begin
                r_z <= i_cfg_data;
            end
            if (i_cmd.train) begin
                if (c0 < CW'(MAX_SAMPLES)) begin
                    r_count <= c0 + 1'b1;
                    r_sum   <= s0 + SUM_W'(x);
                    r_sumsq <= q0 + {{CW{1'b0}}, xx};
                end else begin
                    r_count <= c0;
                    r_sum   <= s0;
                    r_sumsq <= q0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_nx   <= $signed({1'b0, r_count}) * x;
            r_smag <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        end
        if (i_cmd.diff) begin
            r_dmag <= d[DW-1] ? DW'(-d) : DW'(d);
        end
        if (i_cmd.mac) begin
            r_acc <= n_acc;
        end
        if (i_cmd.store) begin
            unique case (i_cmd.sop)
                OP_NSQ:  r_var <= VW'(r_acc);
                OP_SSQ:  r_var <= r_var - VW'(r_acc);
                OP_DSQ:  r_dsq <= (2*DW)'(r_acc);
                default: r_var <= r_var;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out.in_class  <= !(PW'(r_dsq) > r_acc);
            r_out.untrained <= (r_count == '0);
        end
    end

    assign o_out_data = r_out;

endmodule
